[rtl/core/bpfa_pkg.sv]
// Package for the bitmap page frame allocator.
// Holds sizing constants, register and action codes, FSM states and the
// command/status structs shared by the controller, datapath and top level.
package bpfa_pkg;

    // Sizing
    localparam int NUM_FRAMES  = 1024;
    localparam int FRAME_SHIFT = 12;
    localparam int WORD_BITS   = 32;
    localparam int BIT_IDX_W   = 5;
    localparam int ADDR_W      = 32;
    localparam int PCOUNT_W    = 11;
    localparam int PADDR_W     = 3;
    localparam int FRAME_IDX_W = $clog2(NUM_FRAMES);
    localparam int WORD_IDX_W  = (FRAME_IDX_W > BIT_IDX_W) ? FRAME_IDX_W - BIT_IDX_W : 1;
    localparam int IDX_W       = WORD_IDX_W + BIT_IDX_W;
    localparam int MEM_DEPTH   = 1 << WORD_IDX_W;
    localparam int WCNT_W      = WORD_IDX_W + 1;
    localparam int LIMIT_W     = $clog2(NUM_FRAMES + 1);

    // Register index (paddr bit 2)
    localparam logic REG_BASE   = 1'b0;
    localparam logic REG_PCOUNT = 1'b1;

    // Request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE_CALC,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic free_calc;
        logic free_rd;
        logic free_wr;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic limit_zero;
        logic hit;
        logic last_word;
        logic idx_ok;
    } stat_t;

endpackage

[rtl/core/bitmap_page_frame_allocator.sv]
// Top level of the bitmap page frame allocator: APB-style config registers,
// controller and datapath. Depends on bpfa_pkg, bpfa_ctrl and bpfa_dpath.
//
// Usage:
//   Request channel (in_valid/in_ready, action, address): action 0 allocates
//   the lowest free frame below page_count, action 1 frees the frame holding
//   address. Result channel (out_valid/out_ready, ok, frame_address): one
//   result transaction per request, in order.
//   Configuration: base_address at 0x0, page_count at 0x4, written over the
//   APB-style port while no request is in flight; pready is tied high.
// Timing:
//   One request is in flight at a time. An allocate reads the bitmap words in
//   order up to the first one with a free frame (at most page_count/32 rounded
//   up, 32 here); the bitmap memory's single read port delivers one word per
//   cycle. With a page_count of zero an allocate skips the scan. A free reads
//   and writes back its bitmap word, or skips both when the address is out of
//   range. A new request is taken in the cycle after the result is loaded,
//   even while it still waits.
// Reset: all frames free, base_address 0, page_count 1024. Per-word valid bits
//   clear the bitmap at once, so no clearing pass is needed.
// Stall: a result held by out_ready low stays stable; the next finished result
//   waits inside until the slot frees.
module bitmap_page_frame_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpfa_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [bpfa_pkg::ADDR_W-1:0]   address,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic [bpfa_pkg::ADDR_W-1:0]   frame_address
);
    import bpfa_pkg::*;

    logic [ADDR_W-1:0]   base_reg;
    logic [PCOUNT_W-1:0] pcount_reg;
    logic                cfg_wr;
    logic                reg_sel;
    cmd_t                cmd;
    stat_t               stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            pcount_reg <= PCOUNT_W'(1024);
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_BASE:   base_reg   <= pwdata;
                REG_PCOUNT: pcount_reg <= pwdata[PCOUNT_W-1:0];
                default:    base_reg   <= base_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (reg_sel)
            REG_BASE:   prdata = base_reg;
            REG_PCOUNT: prdata = {{(32 - PCOUNT_W){1'b0}}, pcount_reg};
            default:    prdata = '0;
        endcase
    end

    bpfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    bpfa_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .base_address  (base_reg),
        .page_count    (pcount_reg),
        .address       (address),
        .cmd           (cmd),
        .stat          (stat),
        .ok            (ok),
        .frame_address (frame_address)
    );

endmodule

[rtl/core/bpfa_ctrl.sv]
// Controller FSM for the bitmap page frame allocator.
// Sequences the bitmap scan and free steps; depends on bpfa_pkg.
module bpfa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           action,
    output logic           out_valid,
    input  logic           out_ready,
    output bpfa_pkg::cmd_t cmd,
    input  bpfa_pkg::stat_t stat
);
    import bpfa_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (action == ACT_FREE)
                        state_next = ST_FREE_CALC;
                    else if (stat.limit_zero)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit || stat.last_word)
                    state_next = ST_DONE;
            end
            ST_FREE_CALC:
            begin
                cmd.free_calc = 1'b1;
                state_next    = stat.idx_ok ? ST_FREE_RD : ST_DONE;
            end
            ST_FREE_RD:
            begin
                cmd.free_rd = 1'b1;
                state_next  = ST_FREE_WR;
            end
            ST_FREE_WR:
            begin
                cmd.free_wr = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output slot: set on load, cleared when the transaction is taken
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while pending");

    // An allocate with frames to scan enters the scan
    a_alloc_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && action == ACT_ALLOC && !stat.limit_zero) |=> state_reg == ST_SCAN)
        else $error("allocate did not start scan");

    // Input is only taken while no request is in flight
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !in_ready)
        else $error("second request accepted while busy");
`endif

endmodule

[rtl/core/bpfa_dpath.sv]
// Datapath for the bitmap page frame allocator: used-frame bitmap memory,
// word scan with lowest-free search, free index check, result registers.
// Depends on bpfa_pkg.
module bpfa_dpath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [bpfa_pkg::ADDR_W-1:0]    base_address,
    input  logic [bpfa_pkg::PCOUNT_W-1:0]  page_count,
    input  logic [bpfa_pkg::ADDR_W-1:0]    address,
    input  bpfa_pkg::cmd_t                 cmd,
    output bpfa_pkg::stat_t                stat,
    output logic                           ok,
    output logic [bpfa_pkg::ADDR_W-1:0]    frame_address
);
    import bpfa_pkg::*;

    // Bitmap memory and per-word valid bits (invalid word reads as all free)
    logic [WORD_BITS-1:0]  mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]  wvalid_reg;
    logic [WORD_BITS-1:0]  rdata_reg;
    logic                  rvalid_reg;
    logic [WORD_BITS-1:0]  rword;

    logic                  rd_en;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [WORD_IDX_W-1:0] wr_addr;
    logic [WORD_BITS-1:0]  wr_data;

    // Request and scan state
    logic [ADDR_W-1:0]     addr_reg;
    logic [WORD_IDX_W-1:0] chk_reg;
    logic [WCNT_W-1:0]     words_reg;
    logic [BIT_IDX_W-1:0]  tail_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  res_ok_reg;
    logic [ADDR_W-1:0]     res_addr_reg;
    logic                  ok_reg;
    logic [ADDR_W-1:0]     frame_address_reg;

    logic [LIMIT_W-1:0]    limit;
    logic [LIMIT_W:0]      wsum;
    logic [WORD_BITS-1:0]  mask;
    logic [WORD_BITS-1:0]  avail;
    logic [BIT_IDX_W-1:0]  hit_bit;
    logic [IDX_W-1:0]      hit_idx;
    logic [ADDR_W-1:0]     hit_addr;
    logic [ADDR_W:0]       diff;
    logic                  in_range;

    // Effective frame count, saturated at the bitmap size
    assign limit = (32'(page_count) > 32'(NUM_FRAMES)) ? LIMIT_W'(NUM_FRAMES)
                                                        : LIMIT_W'(page_count);
    assign wsum  = (LIMIT_W + 1)'(limit) + (LIMIT_W + 1)'(WORD_BITS - 1);

    assign rword = rvalid_reg ? rdata_reg : '0;

    // Scan: mask off frames past the limit in the last word; status out
    always_comb
    begin
        stat.limit_zero = (limit == '0);
        stat.last_word  = (({1'b0, chk_reg} + WCNT_W'(1)) == words_reg);
        if (stat.last_word && tail_reg != '0)
            mask = (WORD_BITS'(1) << tail_reg) - WORD_BITS'(1);
        else
            mask = '1;
        avail    = ~rword & mask;
        stat.hit = |avail;
        stat.idx_ok = in_range;
    end

    // Lowest free bit
    always_comb
    begin
        hit_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (avail[b])
                hit_bit = BIT_IDX_W'(b);
        end
        hit_idx  = {chk_reg, hit_bit};
        hit_addr = base_address + (ADDR_W'(hit_idx) << FRAME_SHIFT);
    end

    // Free: frame index from address, range check
    always_comb
    begin
        diff        = {1'b0, addr_reg} - {1'b0, base_address};
        in_range    = !diff[ADDR_W] &&
                      ((32'(diff[ADDR_W-1:FRAME_SHIFT])) < 32'(limit));
    end

    // Memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = chk_reg;
        wr_data = rword | (WORD_BITS'(1) << hit_bit);
        if (cmd.accept)
        begin
            rd_en = 1'b1;
        end
        if (cmd.scan)
        begin
            rd_en   = 1'b1;
            rd_addr = chk_reg + WORD_IDX_W'(1);
            wr_en   = stat.hit;
        end
        if (cmd.free_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = idx_reg[BIT_IDX_W +: WORD_IDX_W];
        end
        if (cmd.free_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_reg[BIT_IDX_W +: WORD_IDX_W];
            wr_data = rword & ~(WORD_BITS'(1) << idx_reg[BIT_IDX_W-1:0]);
        end
    end

    // Bitmap memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // Word valid bits and read-valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                wvalid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rvalid_reg <= wvalid_reg[rd_addr];
        end
    end

    // Request registers and result
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg     <= address;
            chk_reg      <= '0;
            words_reg    <= WCNT_W'(wsum >> BIT_IDX_W);
            tail_reg     <= limit[BIT_IDX_W-1:0];
            res_ok_reg   <= 1'b0;
            res_addr_reg <= '0;
        end
        if (cmd.scan)
        begin
            chk_reg <= chk_reg + WORD_IDX_W'(1);
            if (stat.hit)
            begin
                res_ok_reg   <= 1'b1;
                res_addr_reg <= hit_addr;
            end
        end
        if (cmd.free_calc)
            idx_reg <= diff[FRAME_SHIFT +: IDX_W];
        if (cmd.free_wr)
            res_ok_reg <= 1'b1;
        if (cmd.load_out)
        begin
            ok_reg            <= res_ok_reg;
            frame_address_reg <= res_addr_reg;
        end
    end

    assign ok            = ok_reg;
    assign frame_address = frame_address_reg;

`ifndef ASSERT_OFF
    // A scan step is only issued when at least one word is in range
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (words_reg != '0))
        else $error("scan with empty range");

    // A found frame always yields a success result
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && stat.hit) |=> res_ok_reg)
        else $error("hit without success");

    // A free never reaches the write step out of range
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.free_wr |-> $past(cmd.free_rd) && $past(in_range, 2))
        else $error("free write-back without range check");
`endif

endmodule

[bench/tb_top.sv]
// Self-checking bench for bitmap_page_frame_allocator: drives request and APB
// transactions, predicts every result from its own copy of the frame bitmap.
// Depends on bpfa_pkg and the bitmap_page_frame_allocator RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bpfa_pkg::*;

    localparam int FRAME_BYTES   = 1 << FRAME_SHIFT;
    localparam logic [ADDR_W-1:0] TOP_BASE = 32'hFFFF_F000;
    localparam int MAX_SHOWN     = 10;
    localparam int SETTLE_CYCLES = 2;
    localparam int TAIL_CYCLES   = NUM_FRAMES / WORD_BITS + 8;
    localparam int RANDOM_ITEMS  = 300;
    localparam int LONG_HOLD     = 300;
    localparam int EXHAUST_PAGES = 12 * WORD_BITS + 13;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] frame_address;
    } frame_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic                action;
    logic [ADDR_W-1:0]   address;
    logic                out_valid;
    logic                out_ready;
    logic                ok;
    logic [ADDR_W-1:0]   frame_address;

    // Predictor state: config copy and one bit per frame (1 = used)
    logic [ADDR_W-1:0]   cfg_base;
    logic [PCOUNT_W-1:0] cfg_pages;
    logic [NUM_FRAMES-1:0] frame_used;

    frame_result_t frame_results_due[$];
    int  mismatches      = 0;
    int  stray_results   = 0;
    bit  steady_flow     = 1'b0;
    int  hold_off_cycles = 0;

    bitmap_page_frame_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .address       (address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ok            (ok),
        .frame_address (frame_address)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Frames actually managed: page_count saturates at the bitmap size
    function automatic int managed_frames();
        return (cfg_pages > NUM_FRAMES) ? NUM_FRAMES : int'(cfg_pages);
    endfunction

    // First-fit allocate or free against the bitmap copy
    function automatic frame_result_t predict_frame_request(logic act,
                                                            logic [ADDR_W-1:0] addr);
        frame_result_t     r;
        int                limit;
        logic [ADDR_W-1:0] offs;
        r = '0;
        limit = managed_frames();
        if (act == ACT_ALLOC)
        begin
            for (int i = 0; i < limit; i++)
            begin
                if (!frame_used[i])
                begin
                    frame_used[i]   = 1'b1;
                    r.ok            = 1'b1;
                    r.frame_address = cfg_base + (32'(i) << FRAME_SHIFT);
                    break;
                end
            end
        end
        else if (addr >= cfg_base)
        begin
            // partial-frame offsets truncate to the frame holding them
            offs = (addr - cfg_base) >> FRAME_SHIFT;
            if (offs < 32'(limit))
            begin
                frame_used[offs] = 1'b0;
                r.ok             = 1'b1;
            end
        end
        return r;
    endfunction

    // Random used frame below the managed count, -1 if none
    function automatic int pick_used_frame();
        int limit;
        int start;
        int i;
        limit = managed_frames();
        if (limit == 0)
            return -1;
        start = $urandom_range(0, limit - 1);
        for (int k = 0; k < limit; k++)
        begin
            i = (start + k) % limit;
            if (frame_used[i])
                return i;
        end
        return -1;
    endfunction

    // One request transaction; the result is predicted at acceptance
    task automatic send_request(input logic act, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        address  <= addr;
        do @(posedge clk); while (!in_ready);
        frame_results_due.push_back(predict_frame_request(act, addr));
    endtask

    // APB write: setup then access; the predictor copy follows
    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_BASE)
            cfg_base = value;
        else
            cfg_pages = value[PCOUNT_W-1:0];
        @(posedge clk);
    endtask

    // Stop offering requests and let every outstanding result drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reset config: base 0, 1024 frames; first fit, reuse, odd frees
    task automatic test_reset_defaults();
        send_request(ACT_ALLOC, 32'h0);
        send_request(ACT_ALLOC, 32'hFFFF_FFFF);
        send_request(ACT_ALLOC, 32'h5555_5555);
        send_request(ACT_FREE,  32'h0000_1000);
        send_request(ACT_ALLOC, 32'hAAAA_AAAA);
        send_request(ACT_FREE,  32'h0000_2FFF);     // unaligned, frame 2
        send_request(ACT_FREE,  32'h0000_2000);     // double free still ok
        send_request(ACT_FREE,  32'hFFFF_FFFF);     // far beyond the map
        send_request(ACT_FREE,  32'h003F_FFFF);     // last frame, in range
    endtask

    // Zero count, saturated count, unaligned base
    task automatic test_config_extremes();
        wait_idle();
        write_register(REG_PCOUNT, 32'd0);
        send_request(ACT_ALLOC, 32'h0);
        send_request(ACT_FREE,  32'h0);
        wait_idle();
        write_register(REG_PCOUNT, 32'h7FF);
        send_request(ACT_FREE, 32'(NUM_FRAMES - 1) << FRAME_SHIFT);
        send_request(ACT_FREE, 32'(NUM_FRAMES) << FRAME_SHIFT);
        wait_idle();
        write_register(REG_BASE,   32'h0000_0123);
        write_register(REG_PCOUNT, 32'd2);
        send_request(ACT_ALLOC, 32'h0);
        send_request(ACT_FREE,  32'h0000_0123);
        send_request(ACT_ALLOC, 32'h0);
        send_request(ACT_FREE,  32'h0000_0122);     // one below base
    endtask

    // Top-of-space base: allocated addresses wrap past 2^32
    task automatic test_wrapping_base();
        wait_idle();
        write_register(REG_BASE,   TOP_BASE);
        write_register(REG_PCOUNT, 32'd4);
        repeat (3) send_request(ACT_ALLOC, $urandom());
        send_request(ACT_FREE, 32'h0000_0000);      // wrapped, below base
        send_request(ACT_FREE, 32'hFFFF_FFFF);
    endtask

    // Receiver holds off for a long stretch so the block backs up
    task automatic test_output_backpressure();
        wait_idle();
        write_register(REG_BASE,   32'h0);
        write_register(REG_PCOUNT, 32'(NUM_FRAMES));
        hold_off_cycles = LONG_HOLD;
        steady_flow = 1'b1;
        repeat (10)
        begin
            if ($urandom_range(0, 2) == 0)
                send_request(ACT_FREE, $urandom_range(0, 15) << FRAME_SHIFT);
            else
                send_request(ACT_ALLOC, $urandom());
        end
        steady_flow = 1'b0;
    endtask

    // Phases of mixed traffic, each under a fresh random config
    task automatic test_random_traffic();
        int sent;
        int span;
        int pick;
        int kind;
        int idx;
        logic [ADDR_W-1:0] addr;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            pick = $urandom_range(0, 7);
            case (pick)
                0:       addr = 32'h0;
                1:       addr = TOP_BASE - ($urandom_range(0, 8) << FRAME_SHIFT);
                2:       addr = $urandom();
                default: addr = $urandom() & TOP_BASE;
            endcase
            write_register(REG_BASE, addr);
            pick = $urandom_range(0, 11);
            case (pick)
                0:          write_register(REG_PCOUNT, 32'd0);
                1, 2, 3, 4: write_register(REG_PCOUNT, $urandom_range(1, 40));
                5, 6, 7:    write_register(REG_PCOUNT, $urandom_range(41, 300));
                8, 9:       write_register(REG_PCOUNT, 32'(NUM_FRAMES));
                10:         write_register(REG_PCOUNT, $urandom_range(NUM_FRAMES + 1, 2047));
                default:    write_register(REG_PCOUNT, $urandom_range(301, NUM_FRAMES - 1));
            endcase
            steady_flow = ($urandom_range(0, 3) == 0);
            span = $urandom_range(30, 70);
            repeat (span)
            begin
                kind = $urandom_range(0, 99);
                idx = pick_used_frame();
                if (kind < 60 || (kind < 85 && idx < 0))
                    send_request(ACT_ALLOC, $urandom());
                else if (kind < 85)
                    send_request(ACT_FREE, cfg_base + (32'(idx) << FRAME_SHIFT)
                                           + $urandom_range(0, FRAME_BYTES - 1));
                else
                begin
                    // malformed or redundant frees
                    case ($urandom_range(0, 3))
                        0: addr = $urandom();
                        1: addr = (cfg_base == 0) ? $urandom()
                                                  : $urandom_range(0, cfg_base - 1);
                        2: addr = cfg_base
                                  + (32'(managed_frames() + $urandom_range(0, 64))
                                     << FRAME_SHIFT)
                                  + $urandom_range(0, FRAME_BYTES - 1);
                        default: addr = cfg_base
                                        + ($urandom_range(0, NUM_FRAMES - 1) << FRAME_SHIFT);
                    endcase
                    send_request(ACT_FREE, addr);
                end
            end
            sent += span;
        end
        steady_flow = 1'b0;
    endtask

    // Fill every managed frame so scans reach the masked last word, then fail
    // and refill
    task automatic test_exhaust_full_map();
        wait_idle();
        write_register(REG_BASE,   $urandom() & TOP_BASE);
        write_register(REG_PCOUNT, 32'(EXHAUST_PAGES));
        while (!(&frame_used[EXHAUST_PAGES-1:0]))
        begin
            steady_flow = ($urandom_range(0, 7) == 0);
            send_request(ACT_ALLOC, $urandom());
        end
        steady_flow = 1'b0;
        send_request(ACT_ALLOC, $urandom());        // map full
        send_request(ACT_FREE, cfg_base + (32'(EXHAUST_PAGES - 1) << FRAME_SHIFT));
        send_request(ACT_ALLOC, $urandom());        // finds only the last frame
        send_request(ACT_FREE, cfg_base + ($urandom_range(0, EXHAUST_PAGES - 1) << FRAME_SHIFT));
        send_request(ACT_ALLOC, $urandom());
    endtask

    // Result side: random stalls, optional long hold, compare in order
    initial
    begin : result_sink
        frame_result_t want;
        int            stall;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            stall = steady_flow ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (frame_results_due.size() == 0)
            begin
                stray_results++;
                if (stray_results + mismatches <= MAX_SHOWN)
                    $display("%0t: result transaction with nothing pending: ok=%0b addr=%h",
                             $realtime, ok, frame_address);
            end
            else
            begin
                want = frame_results_due.pop_front();
                if (ok !== want.ok || frame_address !== want.frame_address)
                begin
                    mismatches++;
                    if (stray_results + mismatches <= MAX_SHOWN)
                        $display("%0t: mismatch: ok exp %0b got %0b, frame_address exp %h got %h",
                                 $realtime, want.ok, ok, want.frame_address, frame_address);
                end
            end
        end
    end

    // Test sequence
    initial
    begin : test_sequence
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        action   <= ACT_ALLOC;
        address  <= '0;
        cfg_base   = '0;
        cfg_pages  = PCOUNT_W'(NUM_FRAMES);
        frame_used = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_config_extremes();
        test_wrapping_base();
        test_output_backpressure();
        test_random_traffic();
        test_exhaust_full_map();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && stray_results == 0)
            $display("bitmap_page_frame_allocator regression: pass");
        else
            $display("bitmap_page_frame_allocator regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #20_000_000;
        $display("bitmap_page_frame_allocator regression: fail");
        $finish;
    end

endmodule
